// ----- sv/lpc_pkg.sv -----
package lpc_pkg;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int IDX_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int COEF_W     = 18;
  localparam int MAG_W      = COEF_W - 1;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_SHIFT = 17;

  // quarter-wave sine table
  localparam int SINE_DEPTH = 1024;
  localparam int QTR_W      = $clog2(SINE_DEPTH);
  localparam int ADDR_W     = QTR_W + 2;
  localparam int ROM_IDX_W  = QTR_W + 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned COEF_AMP    = 64'd131071;

  // pipeline depth
  localparam int NUM_STAGES = 7;

  // configuration registers
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_OFFSET   = 2'd0;
  localparam logic [1:0] REG_SLOPE    = 2'd1;
  localparam logic [1:0] REG_PIVOT    = 2'd2;
  localparam logic [1:0] REG_NEGPHASE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re_in;
    logic signed [SAMPLE_W-1:0] im_in;
    logic        [IDX_W-1:0]    point_index;
  } lpc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re_out;
    logic signed [SAMPLE_W-1:0] im_out;
  } lpc_out_t;

  typedef logic [MAG_W-1:0] lpc_rom_t [0:SINE_DEPTH];

  // sine of the first quadrant from a q30 taylor series, scaled to 17 bits
  function automatic lpc_rom_t lpc_build_rom();
    lpc_rom_t        rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned scaled;
    longint          sum;
    int              k;
    int              n;
    for (k = 0; k <= SINE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      scaled = (longint'(sum) * COEF_AMP + (64'd1 << 29)) >> 30;
      rom[k] = scaled[MAG_W-1:0];
    end
    return rom;
  endfunction

endpackage

// ----- sv/linear_phase_correction.sv -----
// Linear phase correction: each spectrum point (re_in, im_in, point_index) is rotated by
// phase = phase_offset + (pivot_point - point_index) * phase_slope, taken modulo one turn,
// with cosine and sine read from a 1025-entry quarter-wave table of 17-bit magnitudes
// addressed by the top 12 phase bits. Outputs are re*cos + s*im*sin and im*cos - s*re*sin
// (s = +1 with negative_phase set, else -1), rounded half up and saturated to 24 bits.
// The datapath is a 7-stage pipeline: operand capture, 17x32 phase multiply, phase add and
// table addressing, table read (sine and cosine ports), four 24x18 multipliers, sum with
// rounding, saturation into the output register. It takes one transaction per cycle while
// in_stall is low; a stall at the output only backs up the pipeline once every stage holds
// a transaction, since empty stages keep filling.
// Registers: 0x0 phase_offset, 0x4 phase_slope, 0x8 pivot_point, 0xC negative_phase;
// write them only while the pipeline is empty.
module linear_phase_correction (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lpc_pkg::lpc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lpc_pkg::lpc_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lpc_pkg::*;

  localparam lpc_rom_t SINE_ROM = lpc_build_rom();
  localparam logic [ROM_IDX_W-1:0] DEPTH_IDX = ROM_IDX_W'(SINE_DEPTH);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam int SHIFT_W = ACC_W - FRAC_SHIFT;
  localparam logic signed [SHIFT_W-1:0] SAT_MAX = SHIFT_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SHIFT_W-1:0] SAT_MIN = -SHIFT_W'(1 <<< (SAMPLE_W - 1));

  // configuration registers
  logic [PHASE_W-1:0] phase_offset_r;
  logic [PHASE_W-1:0] phase_slope_r;
  logic [IDX_W-1:0]   pivot_point_r;
  logic               negative_phase_r;
  logic               cfg_wr;
  logic [1:0]         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_offset_r   <= '0;
      phase_slope_r    <= '0;
      pivot_point_r    <= '0;
      negative_phase_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OFFSET:   phase_offset_r   <= pwdata;
        REG_SLOPE:    phase_slope_r    <= pwdata;
        REG_PIVOT:    pivot_point_r    <= pwdata[IDX_W-1:0];
        REG_NEGPHASE: negative_phase_r <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_sel)
      REG_OFFSET:   prdata = phase_offset_r;
      REG_SLOPE:    prdata = phase_slope_r;
      REG_PIVOT:    prdata = {{(32 - IDX_W){1'b0}}, pivot_point_r};
      REG_NEGPHASE: prdata = {31'd0, negative_phase_r};
      default:      prdata = '0;
    endcase
  end

  // stage valids and per-stage advance, empty stages always take new data
  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] vld_nxt;
  logic [NUM_STAGES:1] adv;

  always_comb begin
    adv[NUM_STAGES] = !vld_r[NUM_STAGES] || !out_stall;
    for (int i = NUM_STAGES - 1; i >= 1; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_nxt = {vld_r[NUM_STAGES-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[NUM_STAGES];

  // stage 1: capture samples and the signed distance from the pivot
  logic signed [SAMPLE_W-1:0] s1_re_r, s1_im_r;
  logic signed [IDX_W:0]      s1_diff_r;
  logic signed [IDX_W:0]      diff_nxt;

  assign diff_nxt = signed'({1'b0, pivot_point_r}) - signed'({1'b0, in_data.point_index});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_re_r   <= in_data.re_in;
      s1_im_r   <= in_data.im_in;
      s1_diff_r <= diff_nxt;
    end
  end

  // stage 2: first-order term, kept modulo one turn
  logic signed [SAMPLE_W-1:0] s2_re_r, s2_im_r;
  logic [PHASE_W-1:0]         s2_lin_r;
  logic signed [IDX_W+PHASE_W:0] lin_full;

  assign lin_full = s1_diff_r * signed'(phase_slope_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_re_r  <= s1_re_r;
      s2_im_r  <= s1_im_r;
      s2_lin_r <= lin_full[PHASE_W-1:0];
    end
  end

  // stage 3: total phase, quadrant folding into table indexes
  logic signed [SAMPLE_W-1:0] s3_re_r, s3_im_r;
  logic [ROM_IDX_W-1:0]       s3_sin_idx_r, s3_cos_idx_r;
  logic                       s3_sin_neg_r, s3_cos_neg_r;
  logic [PHASE_W-1:0]         phase_nxt;
  logic [ADDR_W-1:0]          addr;
  logic [1:0]                 quad_sin, quad_cos;
  logic [ROM_IDX_W-1:0]       qtr_off;
  logic [ROM_IDX_W-1:0]       sin_idx_nxt, cos_idx_nxt;

  assign phase_nxt   = phase_offset_r + s2_lin_r;
  assign addr        = phase_nxt[PHASE_W-1 -: ADDR_W];
  assign quad_sin    = addr[ADDR_W-1 -: 2];
  assign quad_cos    = quad_sin + 2'd1;
  assign qtr_off     = {1'b0, addr[QTR_W-1:0]};
  assign sin_idx_nxt = quad_sin[0] ? (DEPTH_IDX - qtr_off) : qtr_off;
  assign cos_idx_nxt = quad_cos[0] ? (DEPTH_IDX - qtr_off) : qtr_off;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_re_r      <= s2_re_r;
      s3_im_r      <= s2_im_r;
      s3_sin_idx_r <= sin_idx_nxt;
      s3_cos_idx_r <= cos_idx_nxt;
      s3_sin_neg_r <= quad_sin[1];
      s3_cos_neg_r <= quad_cos[1];
    end
  end

  // stage 4: table read and sign
  logic signed [SAMPLE_W-1:0] s4_re_r, s4_im_r;
  logic signed [COEF_W-1:0]   s4_sin_r, s4_cos_r;
  logic signed [COEF_W-1:0]   sin_mag, cos_mag;

  assign sin_mag = signed'({1'b0, SINE_ROM[s3_sin_idx_r]});
  assign cos_mag = signed'({1'b0, SINE_ROM[s3_cos_idx_r]});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_re_r  <= s3_re_r;
      s4_im_r  <= s3_im_r;
      s4_sin_r <= s3_sin_neg_r ? -sin_mag : sin_mag;
      s4_cos_r <= s3_cos_neg_r ? -cos_mag : cos_mag;
    end
  end

  // stage 5: four products
  logic signed [PROD_W-1:0] s5_rc_r, s5_is_r, s5_ic_r, s5_rs_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_rc_r <= s4_re_r * s4_cos_r;
      s5_is_r <= s4_im_r * s4_sin_r;
      s5_ic_r <= s4_im_r * s4_cos_r;
      s5_rs_r <= s4_re_r * s4_sin_r;
    end
  end

  // stage 6: rotation sums with the rounding offset
  logic signed [ACC_W-1:0] s6_re_r, s6_im_r;
  logic signed [ACC_W-1:0] rc_x, is_x, ic_x, rs_x;
  logic signed [ACC_W-1:0] re_acc_nxt, im_acc_nxt;

  assign rc_x = ACC_W'(s5_rc_r);
  assign is_x = ACC_W'(s5_is_r);
  assign ic_x = ACC_W'(s5_ic_r);
  assign rs_x = ACC_W'(s5_rs_r);

  always_comb begin
    if (negative_phase_r) begin
      re_acc_nxt = rc_x + is_x + ROUND_HALF;
      im_acc_nxt = ic_x - rs_x + ROUND_HALF;
    end else begin
      re_acc_nxt = rc_x - is_x + ROUND_HALF;
      im_acc_nxt = ic_x + rs_x + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_re_r <= re_acc_nxt;
      s6_im_r <= im_acc_nxt;
    end
  end

  // stage 7: scale down and saturate into the output register
  logic signed [SHIFT_W-1:0]  re_sh, im_sh;
  logic signed [SAMPLE_W-1:0] re_sat_nxt, im_sat_nxt;
  lpc_out_t                   out_data_r;

  assign re_sh = s6_re_r[ACC_W-1:FRAC_SHIFT];
  assign im_sh = s6_im_r[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    priority if (re_sh > SAT_MAX) begin
      re_sat_nxt = SAT_MAX[SAMPLE_W-1:0];
    end else if (re_sh < SAT_MIN) begin
      re_sat_nxt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      re_sat_nxt = re_sh[SAMPLE_W-1:0];
    end
    priority if (im_sh > SAT_MAX) begin
      im_sat_nxt = SAT_MAX[SAMPLE_W-1:0];
    end else if (im_sh < SAT_MIN) begin
      im_sat_nxt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      im_sat_nxt = im_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      out_data_r.re_out <= re_sat_nxt;
      out_data_r.im_out <= im_sat_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ----- sv/lpc_checker.sv -----
module lpc_assertions (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lpc_pkg::lpc_out_t out_data,
  input logic              pready
);
  import lpc_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input backs up only when the output is held up with a full pipeline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without an output stall");

  // register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind linear_phase_correction lpc_assertions u_lpc_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
